@@ design/slip_frame_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// SLIP frame decoder assertion macros
// Concurrent assertion wrappers used by the decoder core (slipd_decode.sv). Building
// with NO_ASSERTIONS defined compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef SLIP_FRAME_DECODER_DEFINES_SVH
`define SLIP_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked assertion, switched off while reset is held.
`define SLIPD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Clocked assertion that is also checked during reset.
`define SLIPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define SLIPD_ASSERT(lbl, clk, rst, prop)
`define SLIPD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ design/slipd_pkg.sv @@
// ----------------------------------------------------------------------------
// SLIP decoder package
// Framing codes, result kinds, the default frame limit and the stage type
// that passes a registered line byte to the decoder.
// ----------------------------------------------------------------------------
package slipd_pkg;

  // Special characters of the SLIP framing scheme.
  localparam logic [7:0] SLIP_END     = 8'hc0;
  localparam logic [7:0] SLIP_ESC     = 8'hdb;
  localparam logic [7:0] SLIP_ESC_END = 8'hdc;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hdd;

  // Default frame limit, in decoded bytes.
  localparam int MAX_FRAME_DEF = 256;

  // Kind of result beat.
  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } event_kind_t;

  // A line byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] line_byte;
  } stage_t;

endpackage

@@ design/slipd_in_if.sv @@
// ----------------------------------------------------------------------------
// SLIP decoder input channel
// Valid/ready channel carrying one received line byte per beat.
// ----------------------------------------------------------------------------
interface slipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink (input valid, input line_byte, output ready);
endinterface

@@ design/slipd_out_if.sv @@
// ----------------------------------------------------------------------------
// SLIP decoder result channel
// Valid/ready channel carrying one decoder event per beat.
// ----------------------------------------------------------------------------
interface slipd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_length;

  modport source (output valid, output event_kind, output data_byte,
                  output byte_index, output frame_length, input ready);
  modport sink (input valid, input event_kind, input data_byte,
                input byte_index, input frame_length, output ready);
endinterface

@@ design/slipd_in_stage.sv @@
// ----------------------------------------------------------------------------
// SLIP decoder input register
// Captures one line byte per beat and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module slipd_in_stage
  import slipd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  slipd_in_if.sink     rx,
  input  logic         take,
  output stage_t       stage
);

  logic       held;
  logic [7:0] held_byte;

  // The register is free when empty or when the decoder takes its byte.
  assign rx.ready = !held || take;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (rx.ready) begin
      held <= rx.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      held_byte <= rx.line_byte;
    end
  end

  assign stage.valid     = held;
  assign stage.line_byte = held_byte;

endmodule

@@ design/slipd_decode.sv @@
// ----------------------------------------------------------------------------
// SLIP decoder core
// Holds the escape, in-frame and count state, decodes the registered line
// byte and loads the result register that drives the result channel.
// ----------------------------------------------------------------------------
`include "slip_frame_decoder_defines.svh"

module slipd_decode
  import slipd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       stage,
  output logic         take,
  slipd_out_if.source  ev
);

  localparam int CNT_W = $clog2(MAX_FRAME);
  localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(MAX_FRAME);

  // Decoder state.
  logic             escape_pending, escape_pending_next;
  logic             in_frame, in_frame_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;

  // Result register.
  logic             out_valid;
  event_kind_t      out_kind;
  logic [7:0]       out_data;
  logic [7:0]       out_index;
  logic [7:0]       out_length;

  // Combinational result.
  logic             have;
  event_kind_t      kind;
  logic [7:0]       data;
  logic [7:0]       index;
  logic [7:0]       length;
  logic             store;
  logic [7:0]       store_byte;
  logic [CNT_W:0]   count_inc;
  logic [CNT_W+7:0] count_wide;
  logic [7:0]       c;
  logic             proc;

  // The result register is free when empty or when its beat is taken.
  assign take = !out_valid || ev.ready;
  assign proc = stage.valid && take;
  assign c    = stage.line_byte;

  assign count_inc  = (CNT_W + 1)'(byte_count) + (CNT_W + 1)'(1);
  assign count_wide = {8'd0, byte_count};

  // Decode one line byte against the current state.
  always_comb begin
    escape_pending_next = escape_pending;
    in_frame_next       = in_frame;
    byte_count_next     = byte_count;
    have                = 1'b0;
    kind                = EV_DATA;
    data                = 8'd0;
    index               = 8'd0;
    length              = 8'd0;
    store               = 1'b0;
    store_byte          = 8'd0;

    if (escape_pending) begin
      // Only the two escape codes decode; anything else is dropped.
      escape_pending_next = 1'b0;
      if (c == SLIP_ESC_END) begin
        store      = 1'b1;
        store_byte = SLIP_END;
      end else if (c == SLIP_ESC_ESC) begin
        store      = 1'b1;
        store_byte = SLIP_ESC;
      end
    end else if (c == SLIP_END) begin
      if (byte_count != '0) begin
        have            = 1'b1;
        kind            = EV_DONE;
        length          = count_wide[7:0];
        byte_count_next = '0;
        in_frame_next   = 1'b0;
      end else begin
        in_frame_next = 1'b1;
      end
    end else if (c == SLIP_ESC) begin
      escape_pending_next = 1'b1;
    end else if (in_frame) begin
      store      = 1'b1;
      store_byte = c;
    end

    // A stored byte that reaches the frame limit aborts the frame.
    if (store) begin
      have  = 1'b1;
      data  = store_byte;
      index = count_wide[7:0];
      if (count_inc >= LIMIT) begin
        kind                = EV_ABORT;
        byte_count_next     = '0;
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
      end else begin
        kind            = EV_DATA;
        byte_count_next = count_inc[CNT_W-1:0];
      end
    end
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      in_frame       <= 1'b0;
      byte_count     <= '0;
    end else if (proc) begin
      escape_pending <= escape_pending_next;
      in_frame       <= in_frame_next;
      byte_count     <= byte_count_next;
    end
  end

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= have;
    end else if (ev.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (proc && have) begin
      out_kind   <= kind;
      out_data   <= data;
      out_index  <= index;
      out_length <= length;
    end
  end

  assign ev.valid        = out_valid;
  assign ev.event_kind   = out_kind;
  assign ev.data_byte    = out_data;
  assign ev.byte_index   = out_index;
  assign ev.frame_length = out_length;

  // An abort leaves the decoder fully cleared.
  `SLIPD_ASSERT(a_abort_clears, clk, rst,
    (proc && have && kind == EV_ABORT) |=>
      (byte_count == '0 && !in_frame && !escape_pending))
  // An escape flag never survives the next processed byte.
  `SLIPD_ASSERT(a_escape_once, clk, rst, (proc && escape_pending) |=> !escape_pending)
  // A completed frame restarts the count.
  `SLIPD_ASSERT(a_done_resets, clk, rst,
    (proc && have && kind == EV_DONE) |=> (byte_count == '0 && !in_frame))
  // A pending result leaves only when the sink takes it.
  `SLIPD_ASSERT(a_no_drop, clk, rst, ($fell(out_valid) && !$past(rst)) |-> $past(ev.ready))
  // The count stays below the frame limit once out of reset.
  `SLIPD_ASSERT(a_count_range, clk, rst, (CNT_W + 1)'(byte_count) < LIMIT)

endmodule

@@ design/slip_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Receive side of SLIP framing: decodes line bytes into data, frame-complete
// and overflow-abort events, each data byte tagged with its frame index.
//
//   Channel  Dir  Payload                                       Beat
//   rx       in   line_byte[7:0]                                one line byte
//   ev       out  event_kind[1:0] data_byte[7:0] byte_index[7:0]
//                 frame_length[7:0]                             one event
//
// A line byte is taken each cycle while rx ready is high; it passes the input
// register and the decode logic into the result register, where its event is
// presented until the sink takes it.
// Bytes that cause no event leave no beat.
// Reset is synchronous and clears the flags, the count and both valid bits.
// A stall on ev holds the result register, then the input register, and
// rx ready drops only when both are full.
// ----------------------------------------------------------------------------
module slip_frame_decoder
  import slipd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  slipd_in_if.sink    rx,
  slipd_out_if.source ev
);

  stage_t stage;
  logic   take;

  // Input register.
  slipd_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  // Decode logic, state and result register.
  slipd_decode #(
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .take  (take),
    .ev    (ev)
  );

endmodule
